// ===== rtl/lhm_pkg.sv =====
// shared constants, types and helpers for the last-heard caller table
// no dependencies; imported by lhm_order, last_heard_mru_table, lhm_tb_pkg and tb
package lhm_pkg;

  localparam int ENTRIES      = 16;
  localparam int IDX_W        = $clog2(ENTRIES);
  localparam int CALLER_W     = 24;
  localparam int DEST_W       = 32;
  localparam int KIND_W       = 8;
  localparam int BYTE_W       = 8;
  localparam int ALIAS_BLOCKS = 4;
  localparam int BLK_W        = $clog2(ALIAS_BLOCKS);
  localparam int ALIAS_ROW_W  = 7 * BYTE_W;
  localparam int ALIAS_DEPTH  = ENTRIES * ALIAS_BLOCKS;
  localparam int ALIAS_AW     = IDX_W + BLK_W;
  localparam int CFG_IDX_W    = 8;

  localparam logic [KIND_W-1:0] KIND_ALIAS_FIRST = 8'h04;
  localparam logic [KIND_W-1:0] KIND_ALIAS_LAST  = 8'h07;
  localparam logic [BLK_W-1:0]  BLK_SHORT        = 2'd0;

  localparam logic [CFG_IDX_W-1:0] CFG_GROUP   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIVATE = 8'd1;

  localparam logic [KIND_W-1:0] GROUP_CODE_RST   = 8'h00;
  localparam logic [KIND_W-1:0] PRIVATE_CODE_RST = 8'h03;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_DECIDE = 8'b0000_0010,
    ST_RANK   = 8'b0000_0100,
    ST_PICK   = 8'b0000_1000,
    ST_MOVE   = 8'b0001_0000,
    ST_ALIAS  = 8'b0010_0000,
    ST_READ   = 8'b0100_0000,
    ST_OUT    = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic                match_en;
    logic                rank_en;
    logic                pick_en;
    logic                move_en;
    logic [CALLER_W-1:0] src;
  } order_ctl_t;

  typedef struct packed {
    logic                hit;
    logic [IDX_W-1:0]    sel;
    logic [IDX_W-1:0]    front;
    logic [CALLER_W-1:0] front_caller;
  } order_sts_t;

  // first alias byte of a stored block; the short block keeps 6 bytes in the low bits
  function automatic logic [BYTE_W-1:0] alias_lead(input logic [BLK_W-1:0] blk,
                                                   input logic [ALIAS_ROW_W-1:0] row);
    logic [BYTE_W-1:0] lead;
    if (blk == BLK_SHORT) begin
      lead = row[ALIAS_ROW_W-BYTE_W-1 -: BYTE_W];
    end else begin
      lead = row[ALIAS_ROW_W-1 -: BYTE_W];
    end
    return lead;
  endfunction

endpackage

// ===== rtl/lhm_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module lhm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/lhm_order.sv =====
// caller ids and recency ranks: match, rank bucketing, pick and move-to-front
// depends on lhm_pkg
module lhm_order (
  input  logic               clk,
  input  logic               rst_n,
  input  lhm_pkg::order_ctl_t ctl,
  output lhm_pkg::order_sts_t sts
);
  import lhm_pkg::*;

  logic [CALLER_W-1:0] caller_r [ENTRIES];
  logic [IDX_W-1:0]    rank_r   [ENTRIES];
  logic [IDX_W-1:0]    rank_nxt [ENTRIES];
  logic [ENTRIES-1:0]  match_r;
  logic [ENTRIES-1:0]  bucket_r;
  logic [ENTRIES-1:0]  bucket_nxt;
  logic [IDX_W-1:0]    sel_r;
  logic [IDX_W-1:0]    front_r;
  logic                hit_r;

  logic [ENTRIES-1:0]  front_vec;
  logic [ENTRIES-1:0]  lru_vec;
  logic [IDX_W-1:0]    lru_idx;
  logic                pick_found;
  logic [IDX_W-1:0]    pick_rank;
  logic [IDX_W-1:0]    pick_idx;
  logic [IDX_W-1:0]    move_rank;

  // ranks are a permutation, so or-encoding gives the single owner
  always_comb begin
    lru_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      front_vec[i] = (rank_r[i] == '0);
      lru_vec[i]   = (rank_r[i] == IDX_W'(ENTRIES - 1));
      if (lru_vec[i]) begin
        lru_idx = lru_idx | IDX_W'(i);
      end
    end
  end

  // matching entries sorted into one bit per rank
  always_comb begin
    bucket_nxt = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_r[i]) begin
        bucket_nxt[rank_r[i]] = 1'b1;
      end
    end
  end

  // lowest matching rank, then the entry holding it
  always_comb begin
    pick_found = 1'b0;
    pick_rank  = '0;
    pick_idx   = '0;
    for (int r = ENTRIES - 1; r >= 0; r--) begin
      if (bucket_r[r]) begin
        pick_found = 1'b1;
        pick_rank  = IDX_W'(r);
      end
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_r[i] && (rank_r[i] == pick_rank)) begin
        pick_idx = pick_idx | IDX_W'(i);
      end
    end
  end

  always_comb begin
    move_rank = rank_r[sel_r];
    for (int i = 0; i < ENTRIES; i++) begin
      if (IDX_W'(i) == sel_r) begin
        rank_nxt[i] = '0;
      end else if (rank_r[i] < move_rank) begin
        rank_nxt[i] = rank_r[i] + 1'b1;
      end else begin
        rank_nxt[i] = rank_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        caller_r[i] <= '0;
        rank_r[i]   <= IDX_W'(i);
      end
      match_r  <= '0;
      bucket_r <= '0;
      sel_r    <= '0;
      front_r  <= '0;
      hit_r    <= 1'b0;
    end else begin
      if (ctl.match_en) begin
        for (int i = 0; i < ENTRIES; i++) begin
          match_r[i] <= (caller_r[i] == ctl.src);
        end
      end
      if (ctl.rank_en) begin
        bucket_r <= bucket_nxt;
      end
      if (ctl.pick_en) begin
        hit_r <= pick_found;
        sel_r <= pick_found ? pick_idx : lru_idx;
      end
      if (ctl.move_en) begin
        for (int i = 0; i < ENTRIES; i++) begin
          rank_r[i] <= rank_nxt[i];
        end
        if (!hit_r) begin
          caller_r[sel_r] <= ctl.src;
        end
        front_r <= sel_r;
      end
    end
  end

  assign sts.hit          = hit_r;
  assign sts.sel          = sel_r;
  assign sts.front        = front_r;
  assign sts.front_caller = caller_r[front_r];

  a_front_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(front_vec)) else $error("rank zero not held by exactly one entry");

  a_lru_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(lru_vec)) else $error("last rank not held by exactly one entry");

  a_front_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    front_vec[front_r]) else $error("front index out of step with ranks");

endmodule

// ===== rtl/last_heard_mru_table.sv =====
// top level of the last-heard caller table: sequencer, alias and destination memories
// depends on lhm_pkg, lhm_ram and lhm_order
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | frame_kind, frame_byte_two, destination_id, source_id
//   out_    | output    | out_valid/out_stall | changed, refresh_display, was_hit, front_caller/dest
//   cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one frame at a time: a call with a new caller passes through match, rank bucketing,
// pick and move, an alias frame through an alias step, anything else straight to the read
// step; the caller search and the registered read data of the destination and alias memories set these steps.
// a finished result sits in the output register, so the next frame is taken while it waits.
// the memories need no clearing pass at reset, per-row valid flops stand in.
// cfg_ready is always high.
module last_heard_mru_table (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [lhm_pkg::KIND_W-1:0]       in_frame_kind,
  input  logic [lhm_pkg::BYTE_W-1:0]       in_frame_byte_two,
  input  logic [lhm_pkg::CALLER_W-1:0]     in_destination_id,
  input  logic [lhm_pkg::CALLER_W-1:0]     in_source_id,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_changed,
  output logic                             out_refresh_display,
  output logic                             out_was_hit,
  output logic [lhm_pkg::CALLER_W-1:0]     out_front_caller,
  output logic [lhm_pkg::DEST_W-1:0]       out_front_destination,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lhm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lhm_pkg::KIND_W-1:0]       cfg_data
);
  import lhm_pkg::*;

  state_t state_r, state_nxt;

  logic [KIND_W-1:0]      kind_r;
  logic [BYTE_W-1:0]      b2_r;
  logic [CALLER_W-1:0]    dst_r;
  logic [CALLER_W-1:0]    src_r;
  logic [KIND_W-1:0]      group_code_r;
  logic [KIND_W-1:0]      private_code_r;
  logic [CALLER_W-1:0]    prev_caller_r;
  logic [DEST_W-1:0]      prev_dest_r;
  logic                   changed_r;
  logic                   refresh_r;
  logic                   hit_flag_r;
  logic [ALIAS_DEPTH-1:0] alias_vld_r;
  logic [ENTRIES-1:0]     dest_vld_r;

  logic                   out_valid_r;
  logic                   out_changed_r;
  logic                   out_refresh_r;
  logic                   out_hit_r;
  logic [CALLER_W-1:0]    out_caller_r;
  logic [DEST_W-1:0]      out_dest_r;

  order_ctl_t             ord_ctl;
  order_sts_t             ord_sts;

  logic                   in_xfer;
  logic                   out_free;
  logic                   is_call;
  logic                   is_alias;
  logic [DEST_W-1:0]      word;
  logic                   new_caller;
  logic                   new_dest;
  logic [BLK_W-1:0]       blk;
  logic [ALIAS_AW-1:0]    alias_addr;
  logic [ALIAS_ROW_W-1:0] alias_rd;
  logic [ALIAS_ROW_W-1:0] alias_wdata;
  logic [BYTE_W-1:0]      alias_first;
  logic                   alias_we;
  logic                   dest_we;
  logic [IDX_W-1:0]       dest_waddr;
  logic [DEST_W-1:0]      dest_rd;
  logic [DEST_W-1:0]      front_dest;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  // call codes win over alias types
  assign is_call    = (kind_r == group_code_r) || (kind_r == private_code_r);
  assign is_alias   = kind_r inside {[KIND_ALIAS_FIRST:KIND_ALIAS_LAST]};
  assign word       = {kind_r, dst_r};
  assign new_caller = (src_r != prev_caller_r);
  assign new_dest   = (word != prev_dest_r);

  assign blk         = kind_r[BLK_W-1:0];
  assign alias_addr  = {ord_sts.front, blk};
  assign alias_first = alias_vld_r[alias_addr] ? alias_lead(blk, alias_rd) : '0;
  assign alias_wdata = (blk == BLK_SHORT) ? {{BYTE_W{1'b0}}, dst_r, src_r}
                                          : {b2_r, dst_r, src_r};
  assign alias_we    = (state_r == ST_ALIAS) && (alias_first == '0);

  assign dest_we    = ((state_r == ST_DECIDE) && is_call && !new_caller && new_dest)
                      || (state_r == ST_MOVE);
  assign dest_waddr = (state_r == ST_MOVE) ? ord_sts.sel : ord_sts.front;
  assign front_dest = dest_vld_r[ord_sts.front] ? dest_rd : '0;

  assign ord_ctl.match_en = (state_r == ST_DECIDE) && is_call && new_caller;
  assign ord_ctl.rank_en  = (state_r == ST_RANK);
  assign ord_ctl.pick_en  = (state_r == ST_PICK);
  assign ord_ctl.move_en  = (state_r == ST_MOVE);
  assign ord_ctl.src      = src_r;

  lhm_order u_order (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ord_ctl),
    .sts   (ord_sts)
  );

  lhm_ram #(.WIDTH(DEST_W), .DEPTH(ENTRIES)) u_dest_ram (
    .clk     (clk),
    .wr_en   (dest_we),
    .wr_addr (dest_waddr),
    .wr_data (word),
    .rd_addr (ord_sts.front),
    .rd_data (dest_rd)
  );

  lhm_ram #(.WIDTH(ALIAS_ROW_W), .DEPTH(ALIAS_DEPTH)) u_alias_ram (
    .clk     (clk),
    .wr_en   (alias_we),
    .wr_addr (alias_addr),
    .wr_data (alias_wdata),
    .rd_addr (alias_addr),
    .rd_data (alias_rd)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (is_call && new_caller) begin
          state_nxt = ST_RANK;
        end else if (!is_call && is_alias) begin
          state_nxt = ST_ALIAS;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_RANK:  state_nxt = ST_PICK;
      ST_PICK:  state_nxt = ST_MOVE;
      ST_MOVE:  state_nxt = ST_READ;
      ST_ALIAS: state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind_r <= in_frame_kind;
      b2_r   <= in_frame_byte_two;
      dst_r  <= in_destination_id;
      src_r  <= in_source_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      group_code_r   <= GROUP_CODE_RST;
      private_code_r <= PRIVATE_CODE_RST;
      prev_caller_r  <= '0;
      prev_dest_r    <= '0;
      changed_r      <= 1'b0;
      refresh_r      <= 1'b0;
      hit_flag_r     <= 1'b0;
      alias_vld_r    <= '0;
      dest_vld_r     <= '0;
      out_valid_r    <= 1'b0;
      out_changed_r  <= 1'b0;
      out_refresh_r  <= 1'b0;
      out_hit_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_GROUP:   group_code_r   <= cfg_data;
          CFG_PRIVATE: private_code_r <= cfg_data;
          default: ;
        endcase
      end

      if (in_xfer) begin
        changed_r  <= 1'b0;
        refresh_r  <= 1'b0;
        hit_flag_r <= 1'b0;
      end

      // same caller, new destination: front entry is always the previous caller
      if ((state_r == ST_DECIDE) && is_call && !new_caller && new_dest) begin
        changed_r   <= 1'b1;
        prev_dest_r <= word;
      end

      if (state_r == ST_MOVE) begin
        changed_r     <= 1'b1;
        refresh_r     <= 1'b1;
        hit_flag_r    <= ord_sts.hit;
        prev_caller_r <= src_r;
        prev_dest_r   <= word;
        if (!ord_sts.hit) begin
          for (int b = 0; b < ALIAS_BLOCKS; b++) begin
            alias_vld_r[{ord_sts.sel, BLK_W'(b)}] <= 1'b0;
          end
        end
      end

      if (alias_we) begin
        alias_vld_r[alias_addr] <= 1'b1;
        refresh_r               <= 1'b1;
      end

      if (dest_we) begin
        dest_vld_r[dest_waddr] <= 1'b1;
      end

      if ((state_r == ST_OUT) && out_free) begin
        out_valid_r   <= 1'b1;
        out_changed_r <= changed_r;
        out_refresh_r <= refresh_r;
        out_hit_r     <= hit_flag_r;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_OUT) && out_free) begin
      out_caller_r <= ord_sts.front_caller;
      out_dest_r   <= front_dest;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_changed           = out_changed_r;
  assign out_refresh_display   = out_refresh_r;
  assign out_was_hit           = out_hit_r;
  assign out_front_caller      = out_caller_r;
  assign out_front_destination = out_dest_r;

  a_front_is_prev: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (ord_sts.front_caller == prev_caller_r))
    else $error("front entry caller differs from previous caller");

  a_dest_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |-> (front_dest == prev_dest_r))
    else $error("front destination read back differs from previous destination");

  a_hit_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_was_hit) |-> (out_changed && out_refresh_display))
    else $error("hit reported without caller change");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result raised outside output state");

endmodule

// ===== dv/lhm_tb_pkg.sv =====
`timescale 1ns / 1ps
// scoreboard for the last-heard caller table: own copy of entries, ranks, aliases and codes
// depends on lhm_pkg for widths, table size, alias kinds and register indexes
package lhm_tb_pkg;
  import lhm_pkg::*;

  localparam int ALIAS_LEN   = 32;
  localparam int SHORT_LEN   = 6;
  localparam int BLOCK_LEN   = 7;
  localparam int MAX_REPORTS = 10;

  localparam logic [KIND_W-1:0] ALIAS_KIND_HEAD = KIND_ALIAS_FIRST;
  localparam logic [KIND_W-1:0] ALIAS_KIND_BODY = 8'h05;
  localparam logic [KIND_W-1:0] ALIAS_KIND_MID  = 8'h06;

  typedef struct packed {
    logic                changed;
    logic                refresh;
    logic                hit;
    logic [CALLER_W-1:0] caller;
    logic [DEST_W-1:0]   dest;
  } frame_result_t;

  class mru_scoreboard;
    logic [CALLER_W-1:0] caller_tab [ENTRIES];
    logic [DEST_W-1:0]   dest_tab [ENTRIES];
    logic [BYTE_W-1:0]   alias_tab [ENTRIES][ALIAS_LEN];
    logic [IDX_W-1:0]    rank_of [ENTRIES];
    logic [CALLER_W-1:0] last_caller;
    logic [DEST_W-1:0]   last_dest;
    logic [KIND_W-1:0]   group_code;
    logic [KIND_W-1:0]   private_code;
    frame_result_t       want_q [$];
    int failures;
    int checked;
    int hits;
    int misses;
    int alias_fills;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        caller_tab[i] = '0;
        dest_tab[i] = '0;
        rank_of[i] = IDX_W'(i);
        for (int k = 0; k < ALIAS_LEN; k++) alias_tab[i][k] = '0;
      end
      last_caller = '0;
      last_dest = '0;
      group_code = GROUP_CODE_RST;
      private_code = PRIVATE_CODE_RST;
      failures = 0;
      checked = 0;
      hits = 0;
      misses = 0;
      alias_fills = 0;
    endfunction

    function int entry_at(int r);
      for (int i = 0; i < ENTRIES; i++) begin
        if (rank_of[i] == r) return i;
      end
      return 0;
    endfunction

    // most recent entry holding the id, -1 if none
    function int search(logic [CALLER_W-1:0] id);
      int best;
      int best_rank;
      best = -1;
      best_rank = ENTRIES;
      for (int i = 0; i < ENTRIES; i++) begin
        if (caller_tab[i] == id && rank_of[i] < best_rank) begin
          best_rank = rank_of[i];
          best = i;
        end
      end
      return best;
    endfunction

    function void promote(int e);
      logic [IDX_W-1:0] r;
      r = rank_of[e];
      for (int i = 0; i < ENTRIES; i++) begin
        if (rank_of[i] < r) rank_of[i] = rank_of[i] + 1'b1;
      end
      rank_of[e] = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [KIND_W-1:0] data);
      if (idx == CFG_GROUP) group_code = data;
      else if (idx == CFG_PRIVATE) private_code = data;
    endfunction

    function void note_frame(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] b2,
                             logic [CALLER_W-1:0] dst, logic [CALLER_W-1:0] src);
      frame_result_t     r;
      logic [DEST_W-1:0] word;
      logic [BYTE_W-1:0] blk [BLOCK_LEN];
      int e;
      int off;
      int len;
      int fr;
      r = '0;
      if (kind == group_code || kind == private_code) begin
        word = {kind, dst};
        if (src != last_caller) begin
          r.changed = 1'b1;
          r.refresh = 1'b1;
          last_caller = src;
          e = search(src);
          if (e >= 0) begin
            r.hit = 1'b1;
            hits++;
          end else begin
            // evict the least recent entry and wipe its alias
            e = entry_at(ENTRIES - 1);
            caller_tab[e] = src;
            for (int k = 0; k < ALIAS_LEN; k++) alias_tab[e][k] = '0;
            misses++;
          end
          dest_tab[e] = word;
          last_dest = word;
          promote(e);
        end else if (last_dest != word) begin
          e = search(src);
          if (e >= 0) dest_tab[e] = word;
          last_dest = word;
          r.changed = 1'b1;
        end
      end else if (kind >= KIND_ALIAS_FIRST && kind <= KIND_ALIAS_LAST) begin
        blk = '{b2, dst[23:16], dst[15:8], dst[7:0], src[23:16], src[15:8], src[7:0]};
        if (kind == ALIAS_KIND_HEAD) begin
          off = 0;
          len = SHORT_LEN;
        end else begin
          off = SHORT_LEN + int'(kind - ALIAS_KIND_BODY) * BLOCK_LEN;
          len = BLOCK_LEN;
        end
        fr = entry_at(0);
        // a block is only filled while its lead byte is still empty
        if (alias_tab[fr][off] == '0) begin
          for (int k = 0; k < len; k++) alias_tab[fr][off + k] = blk[BLOCK_LEN - len + k];
          r.refresh = 1'b1;
          alias_fills++;
        end
      end
      fr = entry_at(0);
      r.caller = caller_tab[fr];
      r.dest = dest_tab[fr];
      want_q.push_back(r);
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t want;
      string         bad;
      if (want_q.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("result with nothing outstanding: caller=%06h dest=%08h", got.caller, got.dest);
        return;
      end
      want = want_q.pop_front();
      checked++;
      bad = "";
      if (got.changed !== want.changed) bad = {bad, " changed"};
      if (got.refresh !== want.refresh) bad = {bad, " refresh_display"};
      if (got.hit !== want.hit) bad = {bad, " was_hit"};
      if (got.caller !== want.caller) bad = {bad, " front_caller"};
      if (got.dest !== want.dest) bad = {bad, " front_destination"};
      if (bad != "") begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("result %0d wrong in%s", checked, bad);
          $display("  expected chg=%0b rfr=%0b hit=%0b caller=%06h dest=%08h",
                   want.changed, want.refresh, want.hit, want.caller, want.dest);
          $display("  actual   chg=%0b rfr=%0b hit=%0b caller=%06h dest=%08h",
                   got.changed, got.refresh, got.hit, got.caller, got.dest);
        end
      end
    endfunction

    function int pending();
      return want_q.size();
    endfunction
  endclass

endpackage

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// top of the last-heard caller table bench: clock, reset, frame and register drivers
// depends on lhm_pkg, lhm_tb_pkg and the last_heard_mru_table rtl
module tb;
  import lhm_pkg::*;
  import lhm_tb_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_FRAMES  = 150;
  localparam int POOL_SIZE     = 24;
  localparam int SETTLE_CYCLES = 10;
  localparam int PHASES        = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_IDX = 8'hFF;
  localparam logic [KIND_W-1:0]    KIND_OTHER_LO = 8'h01;
  localparam logic [KIND_W-1:0]    KIND_OTHER_HI = 8'hFF;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic [KIND_W-1:0]    in_frame_kind = '0;
  logic [BYTE_W-1:0]    in_frame_byte_two = '0;
  logic [CALLER_W-1:0]  in_destination_id = '0;
  logic [CALLER_W-1:0]  in_source_id = '0;
  logic                 out_stall = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [KIND_W-1:0]    cfg_data = '0;
  logic                 in_stall;
  logic                 out_valid;
  logic                 out_changed;
  logic                 out_refresh_display;
  logic                 out_was_hit;
  logic [CALLER_W-1:0]  out_front_caller;
  logic [DEST_W-1:0]    out_front_destination;
  logic                 cfg_ready;

  mru_scoreboard       sb;
  logic [KIND_W-1:0]   grp_code = GROUP_CODE_RST;
  logic [KIND_W-1:0]   prv_code = PRIVATE_CODE_RST;
  logic [CALLER_W-1:0] caller_pool [POOL_SIZE];
  logic [CALLER_W-1:0] last_src = '0;
  logic [CALLER_W-1:0] last_dst = '0;
  bit                  quiet = 1'b0;
  int                  stall_left = 0;
  int                  effective_sent = 0;
  int                  reg_writes = 0;

  last_heard_mru_table dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_frame_kind         (in_frame_kind),
    .in_frame_byte_two     (in_frame_byte_two),
    .in_destination_id     (in_destination_id),
    .in_source_id          (in_source_id),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_changed           (out_changed),
    .out_refresh_display   (out_refresh_display),
    .out_was_hit           (out_was_hit),
    .out_front_caller      (out_front_caller),
    .out_front_destination (out_front_destination),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic bit is_effective(logic [KIND_W-1:0] kind);
    return kind == grp_code || kind == prv_code ||
           (kind >= KIND_ALIAS_FIRST && kind <= KIND_ALIAS_LAST);
  endfunction

  function automatic logic [CALLER_W-1:0] pick_caller();
    int r;
    r = $urandom_range(0, 29);
    if (r < 5) return last_src;
    if (r < 8) return CALLER_W'($urandom());
    return caller_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  // result side: check every transfer, then decide the stall for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_changed, out_refresh_display, out_was_hit,
                       out_front_caller, out_front_destination});
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (!quiet && $urandom_range(0, 3) == 0) stall_left <= gap_len();
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout with %0d results outstanding", sb.pending());
    $display("last_heard_mru_table verification failed");
    $finish;
  end

  task automatic send_frame(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] b2,
                            input logic [CALLER_W-1:0] dst, input logic [CALLER_W-1:0] src);
    int gap;
    gap = quiet ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_frame_kind <= kind;
    in_frame_byte_two <= b2;
    in_destination_id <= dst;
    in_source_id <= src;
    do @(posedge clk); while (in_stall);
    sb.note_frame(kind, b2, dst, src);
    if (is_effective(kind)) effective_sent++;
  endtask

  task automatic send_call(input logic [CALLER_W-1:0] src, input logic [CALLER_W-1:0] dst);
    logic [KIND_W-1:0] kind;
    kind = $urandom_range(0, 1) ? grp_code : prv_code;
    send_frame(kind, BYTE_W'($urandom()), dst, src);
    last_src = src;
    last_dst = dst;
  endtask

  // random alias block, sometimes with an empty lead byte so it stays writable
  task automatic send_alias(input logic [KIND_W-1:0] kind);
    logic [BYTE_W-1:0]   b2;
    logic [CALLER_W-1:0] dst;
    b2 = ($urandom_range(0, 7) == 0) ? '0 : BYTE_W'($urandom());
    dst = CALLER_W'($urandom());
    if ($urandom_range(0, 7) == 0) dst[23:16] = '0;
    send_frame(kind, b2, dst, CALLER_W'($urandom()));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KIND_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_codes(input logic [KIND_W-1:0] g, input logic [KIND_W-1:0] p);
    settle();
    write_reg(CFG_GROUP, g);
    write_reg(CFG_PRIVATE, p);
    grp_code = g;
    prv_code = p;
  endtask

  task automatic run_one();
    int r;
    int n;
    if ($urandom_range(0, 29) == 0) quiet = !quiet;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      // call followed by a run of alias blocks, mostly in order
      send_call(pick_caller(), $urandom_range(0, 3) == 0 ? last_dst : CALLER_W'($urandom()));
      n = $urandom_range(0, 4);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 3) == 0) send_alias(KIND_W'(KIND_ALIAS_FIRST + $urandom_range(0, 3)));
        else send_alias(KIND_W'(KIND_ALIAS_FIRST + k % 4));
      end
    end else if (r < 70) begin
      send_call(last_src, $urandom_range(0, 1) ? last_dst : CALLER_W'($urandom()));
    end else if (r < 85) begin
      send_frame(KIND_W'($urandom()), BYTE_W'($urandom()),
                 CALLER_W'($urandom()), CALLER_W'($urandom()));
    end else if (r < 95) begin
      send_alias(KIND_W'(KIND_ALIAS_FIRST + $urandom_range(0, 3)));
    end else begin
      send_call(CALLER_W'($urandom()), CALLER_W'($urandom()));
    end
  endtask

  initial begin
    logic [KIND_W-1:0] g;
    logic [KIND_W-1:0] p;
    int target;
    sb = new();
    caller_pool[0] = '0;
    caller_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) caller_pool[i] = CALLER_W'($urandom());
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames on the reset codes
    send_frame(GROUP_CODE_RST, 8'h00, 24'h000000, 24'h000000);
    send_frame(PRIVATE_CODE_RST, 8'hFF, 24'hFFFFFF, 24'h000000);
    send_frame(GROUP_CODE_RST, 8'h00, 24'hFFFFFF, 24'hFFFFFF);
    send_frame(ALIAS_KIND_HEAD, 8'h00, 24'hFFFFFF, 24'hFFFFFF);
    send_frame(ALIAS_KIND_BODY, 8'hFF, 24'h000000, 24'h000000);
    send_frame(ALIAS_KIND_MID, 8'h7E, 24'hFFFFFF, 24'h000000);
    send_frame(KIND_ALIAS_LAST, 8'h80, 24'h123456, 24'hABCDEF);
    send_frame(ALIAS_KIND_BODY, 8'h11, 24'h222222, 24'h333333);
    send_frame(ALIAS_KIND_HEAD, 8'h55, 24'h00AAAA, 24'h555555);
    send_frame(ALIAS_KIND_HEAD, 8'hAA, 24'h005555, 24'hAAAAAA);
    send_frame(PRIVATE_CODE_RST, 8'h00, 24'h000001, 24'h123456);
    send_frame(GROUP_CODE_RST, 8'h00, 24'h800000, 24'hFFFFFF);
    send_frame(KIND_ALIAS_LAST, 8'h01, 24'h010101, 24'h010101);
    send_frame(GROUP_CODE_RST, 8'h00, 24'h000002, 24'h000000);
    send_frame(GROUP_CODE_RST, 8'h00, 24'h000002, 24'h000000);
    send_frame(PRIVATE_CODE_RST, 8'h00, 24'h000002, 24'h000000);
    send_frame(KIND_OTHER_LO, 8'hFF, 24'hFFFFFF, 24'hFFFFFF);
    send_frame(KIND_W'(KIND_ALIAS_LAST + 1), 8'h00, 24'h000000, 24'h000000);
    send_frame(KIND_OTHER_HI, 8'h5A, 24'hA5A5A5, 24'h5A5A5A);
    send_frame(KIND_W'(KIND_ALIAS_FIRST - 1), 8'h00, 24'h000000, 24'hFFFFFF);

    settle();
    write_reg(CFG_SPARE, 8'hFF);
    write_reg(CFG_TOP_IDX, 8'h00);

    target = effective_sent;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin g = GROUP_CODE_RST; p = PRIVATE_CODE_RST; end
        1: begin g = 8'hFF; p = 8'h00; end
        2: begin g = ALIAS_KIND_BODY; p = KIND_ALIAS_LAST; end  // calls shadow alias kinds
        3: begin g = 8'hAA; p = 8'h55; end
        4: begin g = 8'h80; p = 8'h80; end
        5: begin g = KIND_W'($urandom()); p = KIND_W'($urandom()); end
        default: begin g = ALIAS_KIND_HEAD; p = 8'hFE; end
      endcase
      set_codes(g, p);
      target += PHASE_FRAMES;
      while (effective_sent < target) run_one();
    end

    settle();
    $display("checked %0d frame results: %0d caller hits, %0d caller misses, %0d alias fills",
             sb.checked, sb.hits, sb.misses, sb.alias_fills);
    $display("%0d register writes over %0d call code settings, %0d mismatches",
             reg_writes, PHASES, sb.failures);
    if (sb.failures == 0) begin
      $display("last_heard_mru_table verification clean");
    end else begin
      $display("last_heard_mru_table verification failed");
    end
    $finish;
  end

endmodule
